>>> rtl/omb_pkg.sv
`default_nettype none
package omb_pkg;

    localparam int CountBitsDef = 32;
    localparam int ProbBitsDef = 16;
    localparam int ContextOrderDef = 3;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_TRAIN = 2'd1;
    localparam logic [1:0] ACT_SCORE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] SRC_QUARTER = 2'd0;
    localparam logic [1:0] SRC_SINGLE = 2'd1;
    localparam logic [1:0] SRC_CONTEXT = 2'd2;

    localparam logic CFG_PSEUDOCOUNT = 1'b0;
    localparam logic CFG_MIN_PROB = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] base;
        logic       base_valid;
        logic       seq_start;
    } t_in_item;

    typedef struct packed {
        logic [ProbBitsDef-1:0] probability;
        logic [1:0]             source;
    } t_out_item;

endpackage
`default_nettype wire

>>> rtl/omb_front.sv
`default_nettype none
// keeps the base history and turns each transaction into a classified command
module omb_front #(
    parameter int CONTEXT_ORDER = 3,
    parameter int CTX_BITS = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire omb_pkg::t_in_item i_item,
    input  wire                   i_valid,
    output logic                  o_stall,
    output logic                  o_cmd_valid,
    input  wire                   i_cmd_stall,
    output logic [1:0]            o_cmd_action,
    output logic [1:0]            o_cmd_base,
    output logic                  o_cmd_base_valid,
    output logic                  o_cmd_ctx_ok,
    output logic [CTX_BITS-1:0]   o_cmd_ctx
);
    import omb_pkg::*;

    logic [CTX_BITS-1:0]      r_hist_base, n_hist_base;
    logic [CONTEXT_ORDER-1:0] r_hist_valid, n_hist_valid;
    logic [$clog2(CONTEXT_ORDER+1)-1:0] r_seen, n_seen;
    logic                     acc;
    logic [CTX_BITS-1:0]      hb;
    logic [CONTEXT_ORDER-1:0] hv;
    logic [$clog2(CONTEXT_ORDER+1)-1:0] sc;

    assign o_stall     = i_cmd_stall;
    assign o_cmd_valid = i_valid && (i_item.action != ACT_UNUSED);
    assign acc         = i_valid && !i_cmd_stall;

    always_comb begin
        hb = i_item.seq_start ? '0 : r_hist_base;
        hv = i_item.seq_start ? '0 : r_hist_valid;
        sc = i_item.seq_start ? '0 : r_seen;
        o_cmd_action     = i_item.action;
        o_cmd_base       = i_item.base;
        o_cmd_base_valid = i_item.base_valid;
        o_cmd_ctx        = hb;
        o_cmd_ctx_ok     = (32'(sc) >= CONTEXT_ORDER) && (&hv);
        n_hist_base  = r_hist_base;
        n_hist_valid = r_hist_valid;
        n_seen       = r_seen;
        if (acc && (i_item.action == ACT_TRAIN || i_item.action == ACT_SCORE)) begin
            n_hist_base  = CTX_BITS'({hb, i_item.base});
            n_hist_valid = CONTEXT_ORDER'({hv, i_item.base_valid});
            n_seen       = (32'(sc) >= CONTEXT_ORDER) ? sc : sc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_base  <= '0;
            r_hist_valid <= '0;
            r_seen       <= '0;
        end else begin
            r_hist_base  <= n_hist_base;
            r_hist_valid <= n_hist_valid;
            r_seen       <= n_seen;
        end
    end
endmodule
`default_nettype wire

>>> rtl/omb_queue.sv
`default_nettype none
// two-entry fifo between front and back
module omb_queue #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_valid,
    input  wire              i_stall,
    output logic [WIDTH-1:0] o_data
);
    import omb_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/omb_back.sv
`default_nettype none
// count store, row total and bit-serial divide
module omb_back #(
    parameter int COUNT_BITS = 32,
    parameter int PROB_BITS = 16,
    parameter int CTX_BITS = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_valid,
    output logic                  o_cmd_stall,
    input  wire [1:0]             i_cmd_action,
    input  wire [1:0]             i_cmd_base,
    input  wire                   i_cmd_base_valid,
    input  wire                   i_cmd_ctx_ok,
    input  wire [CTX_BITS-1:0]    i_cmd_ctx,
    input  wire [7:0]             i_pseudocount,
    input  wire [15:0]            i_min_prob,
    output logic                  o_valid,
    input  wire                   i_stall,
    output omb_pkg::t_out_item    o_item
);
    import omb_pkg::*;

    localparam int NROW = 1 << CTX_BITS;
    localparam int NB = COUNT_BITS + 7;   // 16*count+pc, four-way sum
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [PROB_BITS-1:0] PMAX = '1;
    localparam int SB = $clog2(PROB_BITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WORK  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;

    // context store: one row of four counts per context, per-row valid flags clear it
    logic [4*COUNT_BITS-1:0] r_ctx_mem [NROW];
    logic [4*COUNT_BITS-1:0] r_rd;
    logic [NROW-1:0]         r_row_ok;
    logic [COUNT_BITS-1:0]   r_single [4];

    logic [2:0]            r_st;
    logic [1:0]            r_act, r_base;
    logic                  r_bv, r_cok;
    logic [CTX_BITS-1:0]   r_ctx;
    logic [NB-1:0]         r_tot, r_rem;
    logic [PROB_BITS-1:0]  r_q;
    logic [SB-1:0]         r_i;
    t_out_item             r_out;

    logic [COUNT_BITS-1:0]   row [4];
    logic [NB-1:0]           sc [4];
    logic [NB-1:0]           tot, num;
    logic [NB:0]             sh;
    logic [PROB_BITS-1:0]    qf;
    logic [4*COUNT_BITS-1:0] wr_row;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            row[k] = (r_cok && r_row_ok[r_ctx]) ? r_rd[k*COUNT_BITS +: COUNT_BITS]
                   : (r_cok ? '0 : r_single[k]);
            sc[k] = NB'({row[k], 4'b0}) + NB'(i_pseudocount);
            wr_row[k*COUNT_BITS +: COUNT_BITS] =
                (2'(k) == r_base && row[k] != CMAX) ? row[k] + 1'b1 : row[k];
        end
        tot = sc[0] + sc[1] + sc[2] + sc[3];
        num = sc[r_base];
        sh  = {r_rem, 1'b0};
        qf  = (PROB_BITS'(i_min_prob) > r_q) ? PROB_BITS'(i_min_prob) : r_q;
    end

    assign o_cmd_stall = (r_st != S_IDLE);
    assign o_valid     = (r_st == S_OUT);
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (r_st == S_READ) r_rd <= r_ctx_mem[r_ctx];
        if (r_st == S_WORK && r_act == ACT_TRAIN && r_bv && r_cok)
            r_ctx_mem[r_ctx] <= wr_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_row_ok <= '0;
            for (int k = 0; k < 4; k++) r_single[k] <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_act <= i_cmd_action; r_base <= i_cmd_base;
                    r_bv  <= i_cmd_base_valid; r_cok <= i_cmd_ctx_ok;
                    r_ctx <= i_cmd_ctx;
                    if (i_cmd_action == ACT_CLEAR) begin
                        r_row_ok <= '0;
                        for (int k = 0; k < 4; k++) r_single[k] <= '0;
                    end else r_st <= S_READ;
                end
                S_READ: r_st <= S_WORK;
                S_WORK: begin
                    if (r_act == ACT_TRAIN) begin
                        r_st <= S_IDLE;
                        if (r_bv) begin
                            if (r_single[r_base] != CMAX)
                                r_single[r_base] <= r_single[r_base] + 1'b1;
                            if (r_cok) r_row_ok[r_ctx] <= 1'b1;
                        end
                    end else if (!r_bv) begin
                        r_out <= '{PROB_BITS'(1) << (PROB_BITS-2), SRC_QUARTER};
                        r_st  <= S_OUT;
                    end else begin
                        r_tot <= tot; r_rem <= num; r_i <= '0;
                        // zero total gives quotient 0, full quotient saturates
                        r_q <= (tot != '0 && num >= tot) ? PMAX : '0;
                        if (tot == '0 || num >= tot) r_st <= S_CLR;
                        else r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if ({1'b0, r_tot} <= sh) begin
                        r_rem <= NB'(sh - {1'b0, r_tot}); r_q <= {r_q[PROB_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= NB'(sh); r_q <= {r_q[PROB_BITS-2:0], 1'b0};
                    end
                    r_i <= r_i + 1'b1;
                    if (32'(r_i) == PROB_BITS-1) r_st <= S_CLR;
                end
                S_CLR: begin   // floor and finish
                    r_out <= '{qf, r_cok ? SRC_CONTEXT : SRC_SINGLE};
                    r_st  <= S_OUT;
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/order3_markov_base_model.sv
`default_nettype none
// order-3 markov background model over dna bases
// input channel: i_valid/o_stall carry i_item (action, base, base_valid,
//   seq_start); a transaction is taken when i_valid is high and o_stall low
// output channel: o_valid/i_stall carry o_item (probability q0.16, source);
//   only score transactions produce a result
// config: i_cfg_we with i_cfg_index (0 pseudocount, 1 min_prob), i_cfg_data
// the front keeps the base history and classifies each transaction, then a
//   two-entry queue feeds the back, which owns the count store
// in the back a clear is handled in the idle state and a train passes through read
//   and work; a score passes read, work, PROB_BITS divide steps, floor and output,
//   skipping the divide when the quotient is trivial and going from work to output for an invalid base
// unused actions are taken and dropped by the front
// a clear needs no sweep: per-row valid flags mark the context store empty
// reset is synchronous: counts, history, config and control state go to their defaults
// while the receiver stalls the result holds and the back stops; the queue
//   then fills and the input stall rises
module order3_markov_base_model #(
    parameter int COUNT_BITS = omb_pkg::CountBitsDef,
    parameter int CONTEXT_ORDER = omb_pkg::ContextOrderDef
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire omb_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output omb_pkg::t_out_item     o_item,
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_index,
    input  wire [15:0]             i_cfg_data
);
    import omb_pkg::*;

    localparam int CTX_BITS = 2 * CONTEXT_ORDER;
    localparam int QW = 6 + CTX_BITS;

    logic [7:0]  r_pc;
    logic [15:0] r_minp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 8'd16; r_minp <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PSEUDOCOUNT) r_pc <= i_cfg_data[7:0];
            else r_minp <= i_cfg_data;
        end
    end

    logic f_valid, f_stall, q_valid, q_stall;
    logic [1:0] f_act, f_base;
    logic f_bv, f_cok;
    logic [CTX_BITS-1:0] f_ctx;
    logic [QW-1:0] q_data;

    omb_front #(.CONTEXT_ORDER(CONTEXT_ORDER), .CTX_BITS(CTX_BITS)) u_front (
        .i_clk, .i_rst_n, .i_item, .i_valid, .o_stall,
        .o_cmd_valid(f_valid), .i_cmd_stall(f_stall), .o_cmd_action(f_act),
        .o_cmd_base(f_base), .o_cmd_base_valid(f_bv), .o_cmd_ctx_ok(f_cok),
        .o_cmd_ctx(f_ctx)
    );

    omb_queue #(.WIDTH(QW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall),
        .i_data({f_act, f_base, f_bv, f_cok, f_ctx}),
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_data)
    );

    omb_back #(.COUNT_BITS(COUNT_BITS), .PROB_BITS(ProbBitsDef), .CTX_BITS(CTX_BITS))
    u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(q_valid), .o_cmd_stall(q_stall),
        .i_cmd_action(q_data[QW-1 -: 2]), .i_cmd_base(q_data[QW-3 -: 2]),
        .i_cmd_base_valid(q_data[CTX_BITS+1]), .i_cmd_ctx_ok(q_data[CTX_BITS]),
        .i_cmd_ctx(q_data[CTX_BITS-1:0]), .i_pseudocount(r_pc),
        .i_min_prob(r_minp), .o_valid, .i_stall, .o_item
    );

    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.source <= SRC_CONTEXT) else $error("bad source");
    a_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.source == SRC_QUARTER) |-> o_item.probability == 16'h4000)
        else $error("bad quarter");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
endmodule
`default_nettype wire
